// ----- design/gwmc_pkg.sv -----
// Shared constants, types and sequencer states for the graph walk message counter.
`default_nettype none
package gwmc_pkg;
	localparam int MAX_NODES   = 256;
	localparam int MAX_EDGES   = 1024;
	localparam int COUNT_WIDTH = 64;
	localparam int NODE_W      = 8;
	localparam int NCNT_W      = $clog2(MAX_NODES + 1);
	localparam int NADDR_W     = $clog2(MAX_NODES);
	localparam int EADDR_W     = $clog2(MAX_EDGES);
	localparam int ECNT_W      = $clog2(MAX_EDGES + 1);
	localparam int TICK_W      = 10;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 10;

	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_NODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_COUNT = 2'd2;

	localparam logic CMD_ADD_EDGE = 1'b0;
	localparam logic CMD_RUN      = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLR, ST_START, ST_CPRD, ST_CPWR,
		ST_ED0, ST_ED1, ST_ED2, ST_ED3, ST_ED4, ST_ED5, ST_DONE
	} gwmc_state_t;

	typedef struct packed {
		logic [NCNT_W-1:0] nodes;
		logic [NODE_W-1:0] start_node;
		logic [TICK_W-1:0] ticks;
		logic [ECNT_W-1:0] edges;
	} gwmc_run_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] sent;
		logic                   ovf;
	} gwmc_result_t;
endpackage
`default_nettype wire

// ----- design/gwmc_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module gwmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- design/gwmc_seq.sv -----
// Run sequencer: clears counts, seeds the start node, copies receive to send and walks edges per tick.
`default_nettype none
module gwmc_seq import gwmc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire gwmc_run_t             run,
	output logic      [EADDR_W-1:0]    edge_raddr,
	input  wire logic [2*NODE_W-1:0]   edge_rdata,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output gwmc_result_t               res
);
	gwmc_state_t state_q, state_d;
	logic [NCNT_W-1:0]      idx_q;
	logic [ECNT_W-1:0]      edge_q;
	logic [TICK_W-1:0]      tick_q;
	logic [NODE_W-1:0]      p_q, q_q;
	logic [COUNT_WIDTH-1:0] sp_q, sq_q, sent_q;
	logic                   ovf_q;

	logic                   send_we, recv_we;
	logic [NADDR_W-1:0]     send_waddr, send_raddr, recv_waddr, recv_raddr;
	logic [COUNT_WIDTH-1:0] send_wdata, recv_wdata, send_rd, recv_rd;
	logic [COUNT_WIDTH-1:0] add_val;
	logic [COUNT_WIDTH:0]   recv_sum, sent_sum;
	logic [NODE_W-1:0]      ea, eb;
	logic                   skip, last_node, last_tick;

	assign ea        = edge_rdata[NODE_W-1:0];
	assign eb        = edge_rdata[2*NODE_W-1:NODE_W];
	assign skip      = ({1'b0, ea} >= run.nodes) || ({1'b0, eb} >= run.nodes);
	assign last_node = NCNT_W'(idx_q + 1'b1) == run.nodes;
	assign last_tick = TICK_W'(tick_q + 1'b1) == run.ticks;
	assign add_val   = (state_q == ST_ED3) ? sp_q : sq_q;
	assign recv_sum  = {1'b0, recv_rd} + {1'b0, add_val};
	assign sent_sum  = {1'b0, sent_q} + {1'b0, add_val};

	gwmc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_NODES)) u_send (
		.clk(clk), .we(send_we), .waddr(send_waddr), .wdata(send_wdata),
		.raddr(send_raddr), .rdata(send_rd)
	);
	gwmc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_NODES)) u_recv (
		.clk(clk), .we(recv_we), .waddr(recv_waddr), .wdata(recv_wdata),
		.raddr(recv_raddr), .rdata(recv_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		send_we    = 1'b0;
		recv_we    = 1'b0;
		send_waddr = idx_q[NADDR_W-1:0];
		send_wdata = recv_rd;
		recv_waddr = idx_q[NADDR_W-1:0];
		recv_wdata = '0;
		send_raddr = ea;
		recv_raddr = idx_q[NADDR_W-1:0];
		edge_raddr = edge_q[EADDR_W-1:0];
		res_valid  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CLR;
			end
			ST_CLR: begin
				recv_we = 1'b1;
				if (last_node) state_d = ST_START;
			end
			ST_START: begin
				recv_we    = {1'b0, run.start_node} < run.nodes;
				recv_waddr = run.start_node;
				recv_wdata = COUNT_WIDTH'(1);
				state_d    = (run.ticks == '0) ? ST_DONE : ST_CPRD;
			end
			ST_CPRD: state_d = ST_CPWR;
			ST_CPWR: begin
				send_we = 1'b1;
				recv_we = 1'b1;
				state_d = last_node ? ST_ED0 : ST_CPRD;
			end
			ST_ED0: begin
				if (edge_q == run.edges) begin
					state_d = last_tick ? ST_DONE : ST_CPRD;
				end else begin
					state_d = ST_ED1;
				end
			end
			ST_ED1: state_d = skip ? ST_ED0 : ST_ED2;
			ST_ED2: begin
				send_raddr = q_q;
				recv_raddr = q_q;
				state_d    = ST_ED3;
			end
			ST_ED3: begin
				recv_we    = 1'b1;
				recv_waddr = q_q;
				recv_wdata = recv_sum[COUNT_WIDTH-1:0];
				state_d    = ST_ED4;
			end
			ST_ED4: begin
				recv_raddr = p_q;
				state_d    = ST_ED5;
			end
			ST_ED5: begin
				recv_we    = 1'b1;
				recv_waddr = p_q;
				recv_wdata = recv_sum[COUNT_WIDTH-1:0];
				state_d    = ST_ED0;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			edge_q <= '0;
			tick_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q  <= '0;
					tick_q <= '0;
					ovf_q  <= 1'b0;
				end
				ST_CLR:   idx_q <= last_node ? '0 : NCNT_W'(idx_q + 1'b1);
				ST_START: idx_q <= '0;
				ST_CPWR: begin
					idx_q  <= last_node ? '0 : NCNT_W'(idx_q + 1'b1);
					edge_q <= '0;
				end
				ST_ED0: begin
					if (edge_q == run.edges) tick_q <= TICK_W'(tick_q + 1'b1);
				end
				ST_ED1: begin
					if (skip) edge_q <= ECNT_W'(edge_q + 1'b1);
				end
				ST_ED3: ovf_q <= ovf_q | recv_sum[COUNT_WIDTH] | sent_sum[COUNT_WIDTH];
				ST_ED5: begin
					ovf_q  <= ovf_q | recv_sum[COUNT_WIDTH] | sent_sum[COUNT_WIDTH];
					edge_q <= ECNT_W'(edge_q + 1'b1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_START: sent_q <= '0;
			ST_CPRD:  sent_q <= (idx_q == '0) ? '0 : sent_q;
			ST_ED1: begin
				p_q <= ea;
				q_q <= eb;
			end
			ST_ED2: sp_q <= send_rd;
			ST_ED3: begin
				sq_q   <= send_rd;
				sent_q <= sent_sum[COUNT_WIDTH-1:0];
			end
			ST_ED5: sent_q <= sent_sum[COUNT_WIDTH-1:0];
			default: ;
		endcase
	end

	assign res.sent = sent_q;
	assign res.ovf  = ovf_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < run.nodes || idx_q == '0) else $error("node index past node count");
	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ED1 |-> edge_q < run.edges) else $error("edge read past list");
	a_ovf_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR && $past(state_q) == ST_IDLE |-> !ovf_q)
		else $error("overflow not cleared at run start");
endmodule
`default_nettype wire

// ----- design/graph_walk_message_count.sv -----
// Top level of the graph walk message counter: handshakes, registers, edge store.
//
// Channel   Dir  Payload                                      Transfer when
// s_*       in   tdata: node_a, node_b; tuser: cmd            s_tvalid & s_tready
// m_*       out  tdata: sent_total; tuser: overflow, dropped  m_tvalid & m_tready
// cfg_*     in   cfg_index, cfg_data                          cfg_valid & cfg_ready
//
// After an edge add the next item may follow at once.
// A run first clears the receive counts of the nodes in use and seeds the start node, then
// per tick copies receive to send counts, walks every stored edge, passing over one whose
// endpoint lies past the node count, and closes the tick; the edge steps follow the single
// read port of each count memory, and the result is handed over at the end.
// The sequencer holds the bus until its result lands in the output register, which the
// next items do not wait on unless it is still full.
// Reset clears edge count, full flag, configuration and all handshakes; memories are
// not cleared, since a run clears the counts it uses and edges are read only once written.
`default_nettype none
module graph_walk_message_count import gwmc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [2*NODE_W-1:0]     s_tdata,   // node_a [7:0], node_b [15:8]
	input  wire logic                    s_tuser,   // cmd
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic      [COUNT_WIDTH-1:0]  m_tdata,   // sent_total
	output logic      [1:0]              m_tuser,   // overflow [0], edges_dropped [1]
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data
);
	logic [NCNT_W-1:0]      node_count_q;
	logic [NODE_W-1:0]      start_node_q;
	logic [TICK_W-1:0]      tick_count_q;
	logic [ECNT_W-1:0]      edge_total_q;
	logic                   full_q, busy_q, out_valid_q;
	logic [COUNT_WIDTH-1:0] out_sent_q;
	logic                   out_ovf_q;
	logic                   out_drop_q;
	logic                   in_xfer, add_xfer, run_xfer, room;
	logic                   res_valid, res_ready;
	logic [EADDR_W-1:0]     edge_raddr;
	logic [2*NODE_W-1:0]    edge_rdata;
	gwmc_run_t              run;
	gwmc_result_t           res;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy_q;
	assign in_xfer   = s_tvalid && s_tready;
	assign add_xfer  = in_xfer && (s_tuser == CMD_ADD_EDGE);
	assign run_xfer  = in_xfer && (s_tuser == CMD_RUN);
	assign room      = edge_total_q < ECNT_W'(MAX_EDGES);
	assign res_ready = !out_valid_q || m_tready;

	// Saturate node count into 1..MAX_NODES for the run.
	always_comb begin
		run.nodes = node_count_q;
		if (node_count_q == '0) run.nodes = NCNT_W'(1);
		run.start_node = start_node_q;
		run.ticks      = tick_count_q;
		run.edges      = edge_total_q;
	end

	// Edge store: both endpoints share one word.
	gwmc_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_EDGES)) u_edges (
		.clk(clk), .we(add_xfer && room), .waddr(edge_total_q[EADDR_W-1:0]),
		.wdata(s_tdata), .raddr(edge_raddr), .rdata(edge_rdata)
	);

	gwmc_seq u_seq (
		.clk(clk), .arst_n(arst_n), .start(run_xfer), .run(run),
		.edge_raddr(edge_raddr), .edge_rdata(edge_rdata),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NCNT_W'(MAX_NODES);
			start_node_q <= '0;
			tick_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NODE_COUNT: begin
					// Clamp the low nine data bits down to MAX_NODES if above it; bit 9 is ignored.
					if (cfg_data[NCNT_W-1:0] > NCNT_W'(MAX_NODES)) begin
						node_count_q <= NCNT_W'(MAX_NODES);
					end else begin
						node_count_q <= cfg_data[NCNT_W-1:0];
					end
				end
				REG_START_NODE: start_node_q <= cfg_data[NODE_W-1:0];
				REG_TICK_COUNT: tick_count_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
			full_q       <= 1'b0;
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// Append while there is room, otherwise drop and flag.
			if (add_xfer) begin
				if (room) edge_total_q <= ECNT_W'(edge_total_q + 1'b1);
				else      full_q       <= 1'b1;
			end
			if (run_xfer) busy_q <= 1'b1;
			else if (res_valid && res_ready) busy_q <= 1'b0;
			if (res_valid && res_ready) out_valid_q <= 1'b1;
			else if (m_tready)          out_valid_q <= 1'b0;
		end
	end

	// Hold the drop flag as it stood at the run, since edges may follow before the
	// result is taken.
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_sent_q <= res.sent;
			out_ovf_q  <= res.ovf;
			out_drop_q <= full_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_sent_q;
	assign m_tuser  = {out_drop_q, out_ovf_q};

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_tready) else $error("input taken during run");
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(s_tvalid && s_tuser == CMD_RUN))
		else $error("run started without a run command");
	a_edge_cap: assert property (@(posedge clk) disable iff (!arst_n)
		edge_total_q <= ECNT_W'(MAX_EDGES)) else $error("edge count past capacity");
endmodule
`default_nettype wire
